// ===== sv/clist_pkg.sv =====
// shared types, command and status codes for the cursor list engine
`default_nettype none

package clist_pkg;

  // store size and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 4;
  localparam int ST_W     = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_READ          = 4'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE_FRONT    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE_BACK     = 4'd2;
  localparam logic [CMD_W-1:0] CMD_MOVE_PREV     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_MOVE_NEXT     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_PREPEND       = 4'd5;
  localparam logic [CMD_W-1:0] CMD_APPEND        = 4'd6;
  localparam logic [CMD_W-1:0] CMD_INSERT_BEFORE = 4'd7;
  localparam logic [CMD_W-1:0] CMD_INSERT_AFTER  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DELETE_FRONT  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_DELETE_BACK   = 4'd10;
  localparam logic [CMD_W-1:0] CMD_DELETE_CURSOR = 4'd11;
  localparam logic [CMD_W-1:0] CMD_CLEAR         = 4'd12;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOCURSOR = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  // command beat
  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // response beat
  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [CNT_W-1:0]        list_count;
    logic                    cursor_defined;
    logic [IDX_W-1:0]        cursor_index;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
    logic signed [VAL_W-1:0] cursor_value;
  } rsp_t;

endpackage

`default_nettype wire

// ===== sv/cursor_list_engine.sv =====
// cursor list engine: ordered value list with a cursor, held in a shifting cell row
//
// usage:
//   the command channel (cmd_valid, cmd_stall, cmd) takes one command beat per
//   cycle while cmd_stall is low; each command produces exactly one response
//   beat on the response channel (rsp_valid, rsp_stall, rsp), in command order.
//   a command lands in an input register; when it advances (no stalled
//   response ahead), the whole list update (one parallel shift of the cell row)
//   and the response are computed and written to the state and to the
//   response register.
//   throughput: 1 command per cycle while the receiver does not stall, set by
//   the single cell-row update per command; every command takes the same time.
//   when the receiver stalls, the response holds and the input register keeps
//   one more command; cmd_stall rises once both are occupied.
//   reset (rst, synchronous) empties the list and undefines the cursor; stored
//   values are not cleared, only positions below the count are ever shown.
`default_nettype none

module cursor_list_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire clist_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output clist_pkg::rsp_t    rsp
);
  import clist_pkg::*;

  // input register
  logic in_full;
  cmd_t in_q;
  logic advance;

  // list state
  logic signed [VAL_W-1:0] cells [CAPACITY];
  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        cur_pos;
  logic                    cur_valid;

  // next state
  logic signed [VAL_W-1:0] cells_next [CAPACITY];
  logic signed [VAL_W-1:0] shift_up   [CAPACITY];
  logic signed [VAL_W-1:0] shift_down [CAPACITY];
  logic [CNT_W-1:0]        count_next;
  logic [IDX_W-1:0]        cur_pos_next;
  logic                    cur_valid_next;
  logic [ST_W-1:0]         status_next;
  logic                    ins_en;
  logic                    del_en;
  logic [CNT_W-1:0]        at;
  logic                    full;
  logic [CNT_W-1:0]        cur_ext;
  logic [CNT_W-1:0]        back_pos;
  rsp_t                    rsp_next;

  assign advance   = in_full && (!rsp_valid || !rsp_stall);
  assign cmd_stall = in_full && !advance;

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      in_q <= cmd;
    end
  end

  // command decode and cursor/count update
  assign full    = (count == CNT_W'(CAPACITY));
  assign cur_ext = CNT_W'(cur_pos);

  always_comb begin
    ins_en         = 1'b0;
    del_en         = 1'b0;
    at             = '0;
    status_next    = ST_OK;
    count_next     = count;
    cur_pos_next   = cur_pos;
    cur_valid_next = cur_valid;
    unique case (in_q.command)
      CMD_MOVE_FRONT: begin
        if (count != '0) begin
          cur_valid_next = 1'b1;
          cur_pos_next   = '0;
        end
      end
      CMD_MOVE_BACK: begin
        if (count != '0) begin
          cur_valid_next = 1'b1;
          cur_pos_next   = IDX_W'(count - CNT_W'(1));
        end
      end
      CMD_MOVE_PREV: begin
        if (cur_valid) begin
          if (cur_pos == '0) begin
            cur_valid_next = 1'b0;
            cur_pos_next   = '0;
          end else begin
            cur_pos_next = cur_pos - IDX_W'(1);
          end
        end
      end
      CMD_MOVE_NEXT: begin
        if (cur_valid) begin
          if (cur_ext + CNT_W'(1) >= count) begin
            cur_valid_next = 1'b0;
            cur_pos_next   = '0;
          end else begin
            cur_pos_next = cur_pos + IDX_W'(1);
          end
        end
      end
      CMD_PREPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ins_en     = 1'b1;
          at         = '0;
          count_next = count + CNT_W'(1);
          if (cur_valid) begin
            cur_pos_next = cur_pos + IDX_W'(1);
          end
        end
      end
      CMD_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ins_en     = 1'b1;
          at         = count;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_INSERT_BEFORE, CMD_INSERT_AFTER: begin
        priority if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (!cur_valid) begin
          status_next = ST_NOCURSOR;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ins_en     = 1'b1;
          count_next = count + CNT_W'(1);
          if (in_q.command == CMD_INSERT_BEFORE) begin
            at           = cur_ext;
            cur_pos_next = cur_pos + IDX_W'(1);
          end else begin
            at = cur_ext + CNT_W'(1);
          end
        end
      end
      CMD_DELETE_FRONT: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          del_en     = 1'b1;
          at         = '0;
          count_next = count - CNT_W'(1);
          if (cur_valid) begin
            if (cur_pos == '0) begin
              cur_valid_next = 1'b0;
              cur_pos_next   = '0;
            end else begin
              cur_pos_next = cur_pos - IDX_W'(1);
            end
          end
        end
      end
      CMD_DELETE_BACK: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          del_en     = 1'b1;
          at         = count - CNT_W'(1);
          count_next = count - CNT_W'(1);
          if (cur_valid && (cur_ext + CNT_W'(1) == count)) begin
            cur_valid_next = 1'b0;
            cur_pos_next   = '0;
          end
        end
      end
      CMD_DELETE_CURSOR: begin
        priority if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (!cur_valid) begin
          status_next = ST_NOCURSOR;
        end else begin
          del_en         = 1'b1;
          at             = cur_ext;
          count_next     = count - CNT_W'(1);
          cur_valid_next = 1'b0;
          cur_pos_next   = '0;
        end
      end
      CMD_CLEAR: begin
        count_next     = '0;
        cur_valid_next = 1'b0;
        cur_pos_next   = '0;
      end
      default: begin
      end
    endcase
  end

  // neighbor taps of the cell row
  always_comb begin
    shift_up[0]              = cells[0];
    shift_down[CAPACITY-1]   = cells[CAPACITY-1];
    for (int k = 1; k < CAPACITY; k++) begin
      shift_up[k]     = cells[k-1];
      shift_down[k-1] = cells[k];
    end
  end

  // per-cell select: open a gap at the insert point or close it at the delete point
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      cells_next[k] = cells[k];
      if (ins_en) begin
        if (CNT_W'(k) > at) begin
          cells_next[k] = shift_up[k];
        end else if (CNT_W'(k) == at) begin
          cells_next[k] = in_q.value;
        end
      end else if (del_en) begin
        if (CNT_W'(k) >= at) begin
          cells_next[k] = shift_down[k];
        end
      end
    end
  end

  // response fields from the updated list
  assign back_pos = count_next - CNT_W'(1);

  always_comb begin
    rsp_next.status         = status_next;
    rsp_next.list_count     = count_next;
    rsp_next.cursor_defined = cur_valid_next;
    rsp_next.cursor_index   = cur_valid_next ? cur_pos_next : '0;
    rsp_next.front_value    = (count_next != '0) ? cells_next[0] : '0;
    rsp_next.back_value     = (count_next != '0) ? cells_next[back_pos[IDX_W-1:0]] : '0;
    rsp_next.cursor_value   = cur_valid_next ? cells_next[cur_pos_next] : '0;
  end

  // list state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cur_pos   <= '0;
      cur_valid <= 1'b0;
    end else if (advance) begin
      count     <= count_next;
      cur_pos   <= cur_pos_next;
      cur_valid <= cur_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cells <= cells_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/clist_checker.sv =====
// port-level checks for the cursor list engine, bound into every engine instance
`default_nettype none

module clist_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            rsp_valid,
  input wire logic            rsp_stall,
  input wire clist_pkg::rsp_t rsp
);
  import clist_pkg::*;

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response beat changed under stall");

  // undefined cursor shows index and value zero
  a_cursor_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.cursor_defined |-> rsp.cursor_index == '0 && rsp.cursor_value == '0)
    else $error("undefined cursor with nonzero index or value");

  // empty list has no cursor and zero end values
  a_empty_list: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.list_count == '0 |->
      !rsp.cursor_defined && rsp.front_value == '0 && rsp.back_value == '0)
    else $error("empty list with cursor or end values");

  // cursor stays inside the list and the count inside the store
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.list_count <= CNT_W'(CAPACITY) &&
      (!rsp.cursor_defined || CNT_W'(rsp.cursor_index) < rsp.list_count))
    else $error("cursor or count out of range");

  // a single element is both front and back
  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.list_count == CNT_W'(1) |-> rsp.front_value == rsp.back_value)
    else $error("single element list with differing ends");

endmodule

bind cursor_list_engine clist_checker u_clist_checker (.*);

`default_nettype wire
